/* sv/wear_leveled_counter_ring_macros.svh */
// ---------------------------------------------------------------------------
// wear_leveled_counter_ring_macros
// Assertion macros shared by the wear-leveled counter ring checker.
// ---------------------------------------------------------------------------
`ifndef WEAR_LEVELED_COUNTER_RING_MACROS_SVH
`define WEAR_LEVELED_COUNTER_RING_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define WLCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("wlcr assertion failed");

// Next-cycle implication, off while reset is asserted.
`define WLCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("wlcr assertion failed");

`endif

/* sv/wlcr_pkg.sv */
// ---------------------------------------------------------------------------
// wlcr_pkg
// Types and constants for the wear-leveled counter ring.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wlcr_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int WORD_W         = 16;
  localparam int REC_W          = 2 * WORD_W;
  localparam int SLOT_W         = 4;

  localparam logic [WORD_W-1:0] ERASED_WORD = 16'hFFFF;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DONE
  } wlcr_state_e;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // take the input transaction, run the ring access
    logic load;   // move the result into the output register
  } wlcr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
  } wlcr_sts_t;

endpackage

/* sv/wlcr_ctrl.sv */
// ---------------------------------------------------------------------------
// wlcr_ctrl
// Sequencer: accept one transaction, then hand its result to the output
// register once that register can take it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlcr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wlcr_pkg::wlcr_sts_t sts_i,
  output wlcr_pkg::wlcr_cmd_t cmd_o
);
  import wlcr_pkg::*;

  wlcr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.exec = in_valid_i;
      end
      ST_DONE: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

/* sv/wlcr_dp.sv */
// ---------------------------------------------------------------------------
// wlcr_dp
// Slot storage, marker pointer and output register of the counter ring.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlcr_dp #(
  parameter int SlotCount = wlcr_pkg::SLOT_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wlcr_pkg::wlcr_cmd_t        cmd_i,
  output wlcr_pkg::wlcr_sts_t        sts_o,
  input  logic                       op_i,
  input  logic [wlcr_pkg::REC_W-1:0] write_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [wlcr_pkg::REC_W-1:0] read_value_o,
  output logic [wlcr_pkg::SLOT_W-1:0] slot_o
);
  import wlcr_pkg::*;

  localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int SumW = (IdxW + 1 > SLOT_W) ? IdxW + 1 : SLOT_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

  // Slot words; an entry with its valid bit low reads as erased.
  logic [WORD_W-1:0] hi_mem [SlotCount];
  logic [WORD_W-1:0] lo_mem [SlotCount];
  logic [SlotCount-1:0] hi_vld_q, hi_vld_d;
  logic [SlotCount-1:0] lo_vld_q, lo_vld_d;

  // 0-based index of the first erased high word; the ring always has one.
  logic [IdxW-1:0] first_q, first_d;

  logic [IdxW-1:0]   cur_idx;
  logic [IdxW-1:0]   after_idx;
  logic              is_last;
  logic              new_erased;
  logic [SumW-1:0]   slot_sel;

  logic [WORD_W-1:0] hi_rd_q, lo_rd_q;
  logic              hi_rd_vld_q, lo_rd_vld_q;
  logic              op_q;
  logic [SumW-1:0]   res_slot_q;

  logic              out_vld_q, out_vld_d;
  logic [REC_W-1:0]  read_value_q;
  logic [SLOT_W-1:0] slot_q;
  logic [WORD_W-1:0] hi_eff, lo_eff;

  assign is_last    = (first_q == LastIdx);
  assign cur_idx    = (first_q == '0) ? LastIdx : first_q - 1'b1;
  assign after_idx  = is_last ? '0 : first_q + 1'b1;
  assign new_erased = (write_value_i[REC_W-1:WORD_W] == ERASED_WORD);

  // Write lands on the first erased slot; read reports the slot before it.
  assign slot_sel = (op_i == OP_WRITE) ? SumW'(first_q) + 1'b1 : SumW'(cur_idx) + 1'b1;

  always_comb begin
    hi_vld_d = hi_vld_q;
    lo_vld_d = lo_vld_q;
    first_d  = first_q;
    if (cmd_i.exec && op_i == OP_WRITE) begin
      hi_vld_d[first_q]   = 1'b1;
      lo_vld_d[first_q]   = 1'b1;
      // erase the next high word by dropping its valid bit
      hi_vld_d[after_idx] = 1'b0;
      if (is_last) begin
        first_d = '0;
      end else if (!new_erased) begin
        first_d = first_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_vld_q  <= '0;
      lo_vld_q  <= '0;
      first_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      hi_vld_q  <= hi_vld_d;
      lo_vld_q  <= lo_vld_d;
      first_q   <= first_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (op_i == OP_WRITE) begin
        hi_mem[first_q] <= write_value_i[REC_W-1:WORD_W];
        lo_mem[first_q] <= write_value_i[WORD_W-1:0];
      end else begin
        hi_rd_q <= hi_mem[cur_idx];
        lo_rd_q <= lo_mem[cur_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      op_q        <= op_i;
      res_slot_q  <= slot_sel;
      hi_rd_vld_q <= hi_vld_q[cur_idx];
      lo_rd_vld_q <= lo_vld_q[cur_idx];
    end
  end

  assign hi_eff = hi_rd_vld_q ? hi_rd_q : ERASED_WORD;
  assign lo_eff = lo_rd_vld_q ? lo_rd_q : ERASED_WORD;

  assign sts_o.out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      read_value_q <= (op_q == OP_READ) ? {hi_eff, lo_eff} : '0;
      slot_q       <= res_slot_q[SLOT_W-1:0];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign read_value_o = read_value_q;
  assign slot_o       = slot_q;

endmodule

/* sv/wear_leveled_counter_ring.sv */
// ---------------------------------------------------------------------------
// wear_leveled_counter_ring
// Flow: an accepted transaction runs its slot memory read or write, and its
// result is then loaded into the output register; no new transaction is
// taken until that load. A stalled result holds off the next transaction
// until the output register drains.
// Reset: asynchronous; every slot reads erased, the marker sits on slot 1,
// and no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wear_leveled_counter_ring #(
  parameter int SLOT_COUNT = wlcr_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [wlcr_pkg::REC_W-1:0]  write_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wlcr_pkg::REC_W-1:0]  read_value_o,
  output logic [wlcr_pkg::SLOT_W-1:0] slot_o
);
  import wlcr_pkg::*;

  wlcr_cmd_t cmd;
  wlcr_sts_t sts;

  wlcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wlcr_dp #(
    .SlotCount (SLOT_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .slot_o        (slot_o)
  );

endmodule

/* sv/wlcr_checker.sv */
// ---------------------------------------------------------------------------
// wlcr_checker
// Port-level checks for the wear-leveled counter ring.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wear_leveled_counter_ring_macros.svh"

module wlcr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [wlcr_pkg::REC_W-1:0]  read_value_o,
  input logic [wlcr_pkg::SLOT_W-1:0] slot_o
);

  // one transaction in flight: hold off input right after an accept
  `WLCR_ASSERT_NXT(a_stall_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // stalled result holds
  `WLCR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(read_value_o) && $stable(slot_o))

  // a new result only comes from a transaction in progress
  `WLCR_ASSERT_IMP(a_out_from_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind wear_leveled_counter_ring wlcr_checker u_wlcr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o),
  .slot_o       (slot_o)
);

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the wear-leveled counter ring. A directed table of
// reads and writes (post-reset read, record extremes, high halves that look
// like the erased marker, wrap of the ring) is followed by randomized traffic.
// Each accepted transaction runs through a local model of the slot ring, and
// every result is compared field by field in order. The sender works in
// bursts, the receiver stalls on patterns of its own and once holds off long
// enough to back up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import wlcr_pkg::*;

  localparam int N_SLOTS        = SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS   = 1325;
  localparam int HOLD_AT_ITEM   = 400;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct packed {
    logic [REC_W-1:0]  rec;
    logic [SLOT_W-1:0] slot;
  } ring_result_t;

  typedef struct packed {
    logic              op;
    logic [REC_W-1:0]  value;
    bit                pinned;
    logic [REC_W-1:0]  rec;
    logic [SLOT_W-1:0] slot;
  } stim_row_t;

  localparam int DIR_N = 25;
  // pinned rows carry their result; the rest take theirs from the ring model
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{OP_READ,  32'h1234_5678, 1'b1, 32'hFFFF_FFFF, 4'd8},
    '{OP_WRITE, 32'h0000_0000, 1'b1, 32'h0000_0000, 4'd1},
    '{OP_WRITE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 4'd2},
    '{OP_READ,  32'h0000_0000, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h0000_FFFF, 1'b0, 32'h0, 4'd0},
    '{OP_READ,  32'hFFFF_FFFF, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'hFFFF_0000, 1'b0, 32'h0, 4'd0},
    '{OP_READ,  32'h0000_0000, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h8000_0000, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h7FFF_FFFF, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'hAAAA_5555, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h5555_AAAA, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'hFFFE_FFFF, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h0001_0000, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'hDEAD_BEEF, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h1357_9BDF, 1'b0, 32'h0, 4'd0},
    '{OP_READ,  32'hFFFF_FFFF, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h2468_ACE0, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h0F0F_0F0F, 1'b0, 32'h0, 4'd0},
    '{OP_READ,  32'h0000_0000, 1'b0, 32'h0, 4'd0},
    '{OP_READ,  32'hA5A5_A5A5, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'hFFFF_FFFF, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'hFFFF_FFFF, 1'b0, 32'h0, 4'd0},
    '{OP_READ,  32'h5A5A_5A5A, 1'b0, 32'h0, 4'd0},
    '{OP_WRITE, 32'h0000_0001, 1'b0, 32'h0, 4'd0}
  };

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              op_i          = OP_READ;
  logic [REC_W-1:0]  write_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [REC_W-1:0]  read_value_o;
  logic [SLOT_W-1:0] slot_o;

  wear_leveled_counter_ring #(
    .SLOT_COUNT(N_SLOTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .write_value_i(write_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .slot_o       (slot_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // local copy of the slot ring
  logic [WORD_W-1:0] ring_hi [N_SLOTS];
  logic [WORD_W-1:0] ring_lo [N_SLOTS];

  ring_result_t due_results [$];

  int fail_cnt       = 0;
  int items_in       = 0;
  int reads_in       = 0;
  int writes_in      = 0;
  int marker_writes  = 0;
  int results_seen   = 0;
  int backup_cycles  = 0;
  int idle_cycles    = 0;
  int burst_left     = 0;
  bit hold_done      = 1'b0;

  function automatic int next_slot(input int s);
    return (s % N_SLOTS) + 1;
  endfunction

  // Search the ring for the current slot, then apply one transaction.
  function automatic ring_result_t ring_access(input logic op, input logic [REC_W-1:0] val);
    ring_result_t res;
    int           cur;
    int           target;
    int           after;
    bit           found;
    int           k;
    cur   = 0;
    found = 1'b0;
    for (k = 1; k <= N_SLOTS; k++) begin
      if (!found && ring_hi[k-1] == ERASED_WORD) begin
        found = 1'b1;
        cur   = (k == 1) ? N_SLOTS : k - 1;
      end
    end
    if (op == OP_READ) begin
      res.rec  = (cur != 0) ? {ring_hi[cur-1], ring_lo[cur-1]} : '0;
      res.slot = SLOT_W'(cur);
    end else begin
      target              = next_slot(cur);
      after               = next_slot(target);
      ring_hi[target-1]   = val[REC_W-1:WORD_W];
      ring_lo[target-1]   = val[WORD_W-1:0];
      ring_hi[after-1]    = ERASED_WORD;
      res.rec             = '0;
      res.slot            = SLOT_W'(target);
    end
    return res;
  endfunction

  // Offer one transaction and hold it until accepted, then record what is due.
  task automatic offer_transaction(input logic op, input logic [REC_W-1:0] val,
                                   input bit pinned, input ring_result_t typed);
    ring_result_t want;
    in_valid_i    <= 1'b1;
    op_i          <= op;
    write_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = ring_access(op, val);
    if (pinned) want = typed;
    due_results.push_back(want);
    items_in++;
    if (op == OP_READ) begin
      reads_in++;
    end else begin
      writes_in++;
      if (val[REC_W-1:WORD_W] == ERASED_WORD) marker_writes++;
    end
  endtask

  // End a burst with a random gap; some bursts run straight into the next.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [REC_W-1:0] pick_value();
    logic [REC_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = {ERASED_WORD, 16'($urandom())};
      2: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'hFFFF_0000;
          3: v = 32'h0000_FFFF;
          4: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  initial begin
    ring_result_t typed;
    logic         op;
    int           i;
    for (i = 0; i < N_SLOTS; i++) begin
      ring_hi[i] = ERASED_WORD;
      ring_lo[i] = ERASED_WORD;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 24);

    for (i = 0; i < DIR_N; i++) begin
      typed.rec  = DIR_ROWS[i].rec;
      typed.slot = DIR_ROWS[i].slot;
      offer_transaction(DIR_ROWS[i].op, DIR_ROWS[i].value, DIR_ROWS[i].pinned, typed);
      pace_sender();
    end

    typed = '0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // lean toward writes so the marker keeps moving around the ring
      op = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ;
      offer_transaction(op, pick_value(), 1'b0, typed);
      pace_sender();
    end
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions (%0d reads, %0d writes, %0d with an erased-looking high half)",
             items_in, reads_in, writes_in, marker_writes);
    $display("Checked %0d results; input backed up for %0d cycles", results_seen, backup_cycles);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: move through random stall patterns, hold off once for a long stretch.
  initial begin
    int stall_mode;
    int phase_cnt;
    stall_mode = 0;
    phase_cnt  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && items_in >= HOLD_AT_ITEM) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      phase_cnt++;
      if (phase_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= phase_cnt[0];
      endcase
    end
  end

  always @(posedge clk_i) begin
    ring_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) backup_cycles++;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result with nothing due: read_value %h slot %0d", read_value_o, slot_o);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          if (read_value_o !== want.rec) begin
            $error("read_value mismatch: expected %h, actual %h", want.rec, read_value_o);
            fail_cnt++;
          end
          if (slot_o !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, slot_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
